// ===== src/hll_pkg.sv =====
// ----------------------------------------------------------------------------
// hll_pkg
// Shared types, opcodes and constants of the HyperLogLog sketch core.
// ----------------------------------------------------------------------------
package hll_pkg;

  // Operation codes carried in the opcode field.
  localparam logic [2:0] OP_ADD      = 3'd0;
  localparam logic [2:0] OP_MERGE    = 3'd1;
  localparam logic [2:0] OP_LOAD     = 3'd2;
  localparam logic [2:0] OP_READ     = 3'd3;
  localparam logic [2:0] OP_ESTIMATE = 3'd4;

  localparam int unsigned RANK_W     = 5;
  localparam int unsigned HASH_W     = 32;
  localparam int unsigned CARD_W     = 32;
  localparam int unsigned EST_W      = 64;   // Q16 raw estimate
  localparam int unsigned LOG_IN_W   = 48;   // argument of the logarithm unit
  localparam int unsigned LOG_W      = 38;   // six integer bits, 32 fraction bits
  localparam int unsigned DIV_EXTRA  = 27;   // extra quotient bits of the estimate
  localparam logic [29:0] LN2_Q30    = 30'd744261118;

  typedef struct packed {
    logic [2:0]        opcode;
    logic [HASH_W-1:0] hash_value;
    logic [9:0]        reg_index;
    logic [RANK_W-1:0] reg_value;
  } in_item_t;

  typedef struct packed {
    logic [RANK_W-1:0] read_value;
    logic [CARD_W-1:0] cardinality;
    logic              saturated;
    logic              changed;
  } out_item_t;

  // Number of leading zeros of a 32-bit word; 32 for a zero word.
  function automatic logic [5:0] clz32(input logic [31:0] v);
    logic [5:0] n;
    n = 6'd32;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) begin
        n = 6'(31 - i);
      end
    end
    return n;
  endfunction

endpackage

// ===== src/hll_if.sv =====
// ----------------------------------------------------------------------------
// hll_in_if / hll_out_if
// Valid/ready channels that carry input items and result items.
// ----------------------------------------------------------------------------
interface hll_in_if;
  logic              valid;
  logic              ready;
  hll_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface hll_out_if;
  logic               valid;
  logic               ready;
  hll_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/hll_ram.sv =====
// ----------------------------------------------------------------------------
// hll_ram
// Rank register store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hll_ram #(
  parameter int unsigned AW = 10,
  parameter int unsigned DW = 5
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  localparam int unsigned DEPTH = 1 << AW;

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] rd_data_r;

  // Write and read happen in the same clocked block; read data is registered.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/hll_div.sv =====
// ----------------------------------------------------------------------------
// hll_div
// Restoring long divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hll_div #(
  parameter int unsigned N_W = 67,
  parameter int unsigned D_W = 42,
  parameter int unsigned Q_W = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [N_W-1:0] dividend,
  input  logic [D_W-1:0] divisor,
  output logic           done,
  output logic [Q_W-1:0] quotient
);

  localparam int unsigned CNT_W = $clog2(N_W + 1);

  logic [N_W-1:0]   num_r;
  logic [D_W-1:0]   div_r;
  logic [D_W:0]     rem_r;
  logic [Q_W-1:0]   q_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [D_W:0]     rem_sh;
  logic             q_bit;

  // Shift in the next dividend bit and try to subtract the divisor.
  assign rem_sh = {rem_r[D_W-1:0], num_r[N_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, div_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      // The last quotient bit is taken in the cycle that flags completion.
      done_r <= !start && busy_r && (cnt_r == CNT_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        num_r  <= dividend;
        div_r  <= divisor;
        rem_r  <= '0;
        q_r    <= '0;
        cnt_r  <= CNT_W'(N_W);
      end else if (busy_r) begin
        num_r <= num_r << 1;
        rem_r <= q_bit ? (rem_sh - {1'b0, div_r}) : rem_sh;
        q_r   <= {q_r[Q_W-2:0], q_bit};
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ===== src/hll_log2.sv =====
// ----------------------------------------------------------------------------
// hll_log2
// Base-2 logarithm with 32 fraction bits: a bit-per-cycle normalising shift
// followed by 32 squaring steps of the Q31 mantissa.
// ----------------------------------------------------------------------------
module hll_log2 (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [hll_pkg::LOG_IN_W-1:0]  value,
  output logic                          done,
  output logic [hll_pkg::LOG_W-1:0]     result
);

  typedef enum logic [1:0] {S_IDLE, S_NORM, S_SQUARE} lstate_t;

  lstate_t                        state_r;
  logic [hll_pkg::LOG_IN_W-1:0]   v_r;
  logic [5:0]                     n_r;
  logic [31:0]                    y_r;
  logic [31:0]                    frac_r;
  logic [5:0]                     cnt_r;
  logic                           done_r;
  logic [63:0]                    prod;
  logic [32:0]                    sq;

  // One squaring per cycle; the mantissa is registered between steps.
  assign prod = y_r * y_r;
  assign sq   = prod[63:31];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      // Completion is flagged alongside the last squaring step.
      done_r <= (state_r == S_SQUARE) && (cnt_r == 6'd1);
      case (state_r)
        S_IDLE: begin
          if (start) begin
            v_r     <= value;
            n_r     <= 6'(hll_pkg::LOG_IN_W - 1);
            frac_r  <= '0;
            state_r <= S_NORM;
          end
        end
        S_NORM: begin
          // Shift left until the top bit is set; n_r tracks the exponent.
          if (v_r[hll_pkg::LOG_IN_W-1] || n_r == 6'd0) begin
            y_r     <= v_r[hll_pkg::LOG_IN_W-1 -: 32];
            cnt_r   <= 6'd32;
            state_r <= S_SQUARE;
          end else begin
            v_r <= v_r << 1;
            n_r <= n_r - 6'd1;
          end
        end
        S_SQUARE: begin
          frac_r <= {frac_r[30:0], sq[32]};
          y_r    <= sq[32] ? sq[32:1] : sq[31:0];
          cnt_r  <= cnt_r - 6'd1;
          if (cnt_r == 6'd1) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign done   = done_r;
  assign result = {n_r, frac_r};

endmodule

// ===== src/hyperloglog_sketch_core.sv =====
// ----------------------------------------------------------------------------
// hyperloglog_sketch_core
// HyperLogLog cardinality sketch with 2^PRECISION five-bit rank registers.
// ----------------------------------------------------------------------------
// Items arrive on in_ch (valid/ready); each one yields exactly one result on
// out_ch. For add, merge, load, read and unknown opcodes the transfer cycle
// issues the memory read; the execute step then modifies and writes back the
// entry and fills the output register once that register is free. The
// memory's registered read port sets this order.
// Estimate walks every register through the read port, runs a bit-serial
// divide and, when a correction applies, a logarithm (normalising shift, then
// squaring steps) and a multiply.
// After reset the store is cleared one entry a cycle while in_ch.ready stays
// low. A result waits in the output register while the receiver stalls; the
// next item is taken meanwhile and holds in its last step until the output
// register is free.
// ----------------------------------------------------------------------------
module hyperloglog_sketch_core #(
  parameter int unsigned PRECISION = 10
) (
  input  logic       clk,
  input  logic       rst_n,
  hll_in_if.sink     in_ch,
  hll_out_if.source  out_ch
);

  localparam int unsigned M        = 1 << PRECISION;
  localparam int unsigned S_W      = PRECISION + 32;
  localparam int unsigned NUM_W    = 2 * PRECISION + 20;
  localparam int unsigned DIVD_W   = NUM_W + hll_pkg::DIV_EXTRA;
  localparam logic [63:0] ALPHA_Q20 =
      (M == 16) ? ((64'd673 << 20) / 64'd1000) :
      (M == 32) ? ((64'd697 << 20) / 64'd1000) :
      (M == 64) ? ((64'd709 << 20) / 64'd1000) :
      (((64'd7213 * M) << 20) / (64'd10000 * M + 64'd10790));
  localparam logic [63:0] NUM       = ALPHA_Q20 * M * M;
  localparam logic [63:0] LIN_THR   = 64'd5 << (PRECISION + 15);
  localparam logic [63:0] LARGE_THR = (64'd1 << 48) / 64'd30;
  localparam logic [63:0] TOP_E     = 64'd1 << 48;
  localparam logic [hll_pkg::LOG_W-1:0] LIN_BASE   =
      hll_pkg::LOG_W'(PRECISION) << 32;
  localparam logic [hll_pkg::LOG_W-1:0] LARGE_BASE = hll_pkg::LOG_W'(48) << 32;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_EXEC, ST_WALK, ST_DIV, ST_SEL, ST_LOG, ST_MUL,
    ST_SCALE, ST_DONE
  } state_t;

  state_t                      state_r;
  logic [PRECISION:0]          walk_cnt_r;
  logic                        acc_vld_r;
  logic [2:0]                  op_r;
  logic [PRECISION-1:0]        idx_r;
  logic [hll_pkg::RANK_W-1:0]  val_r;
  logic [S_W-1:0]              s_r;
  logic [PRECISION:0]          zeros_r;
  logic [hll_pkg::EST_W-1:0]   e_r;
  logic                        lin_r;
  logic [59:0]                 prod_r;
  logic [hll_pkg::CARD_W-1:0]  card_r;
  logic                        sat_r;
  logic                        out_valid_r;
  hll_pkg::out_item_t          out_data_r;

  logic                        accept;
  logic                        out_free;
  logic                        out_load;
  logic [31:0]                 rest;
  logic [hll_pkg::RANK_W-1:0]  rank;
  logic [15:0]                 ridx_ext;
  logic [PRECISION-1:0]        item_idx;
  logic [hll_pkg::RANK_W-1:0]  item_val;
  logic                        mem_wr_en;
  logic [PRECISION-1:0]        mem_wr_addr;
  logic [hll_pkg::RANK_W-1:0]  mem_wr_data;
  logic                        mem_rd_en;
  logic [PRECISION-1:0]        mem_rd_addr;
  logic [hll_pkg::RANK_W-1:0]  mem_rd_data;
  logic                        exec_raise;
  logic                        exec_wr;
  hll_pkg::out_item_t          exec_out;
  logic [31:0]                 term;
  logic                        div_start;
  logic                        div_done;
  logic [hll_pkg::EST_W-1:0]   div_q;
  logic                        log_start;
  logic [hll_pkg::LOG_IN_W-1:0] log_in;
  logic                        log_done;
  logic [hll_pkg::LOG_W-1:0]   log_res;
  logic [hll_pkg::LOG_W-1:0]   diff;
  logic [63:0]                 lin_card;
  logic [37:0]                 large_res;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign out_load = ((state_r == ST_EXEC) || (state_r == ST_DONE)) && out_free;
  assign in_ch.ready = (state_r == ST_IDLE);

  // Index and rank (or given register value) of an incoming item.
  assign rest     = in_ch.data.hash_value << PRECISION;
  assign rank     = (rest == 32'd0) ? hll_pkg::RANK_W'(33 - PRECISION)
                                    : hll_pkg::RANK_W'(hll_pkg::clz32(rest) + 6'd1);
  assign ridx_ext = 16'(in_ch.data.reg_index);
  assign item_idx = (in_ch.data.opcode == hll_pkg::OP_ADD)
                    ? in_ch.data.hash_value[PRECISION-1:0]
                    : ridx_ext[PRECISION-1:0];
  assign item_val = (in_ch.data.opcode == hll_pkg::OP_ADD) ? rank
                                                           : in_ch.data.reg_value;

  // Read-modify-write decision on the entry read back from the store.
  always_comb begin
    exec_raise = 1'b0;
    exec_wr    = 1'b0;
    exec_out   = '0;
    case (op_r)
      hll_pkg::OP_ADD, hll_pkg::OP_MERGE: begin
        exec_raise       = (val_r > mem_rd_data);
        exec_wr          = exec_raise;
        exec_out.changed = exec_raise;
      end
      hll_pkg::OP_LOAD: begin
        exec_wr = 1'b1;
      end
      hll_pkg::OP_READ: begin
        exec_out.read_value = mem_rd_data;
      end
      default: begin
        exec_wr = 1'b0;
      end
    endcase
  end

  // Memory port control: clearing pass, item access and estimate walk.
  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = idx_r;
    mem_wr_data = val_r;
    mem_rd_en   = 1'b0;
    mem_rd_addr = walk_cnt_r[PRECISION-1:0];
    case (state_r)
      ST_CLEAR: begin
        mem_wr_en   = !walk_cnt_r[PRECISION];
        mem_wr_addr = walk_cnt_r[PRECISION-1:0];
        mem_wr_data = '0;
      end
      ST_IDLE: begin
        mem_rd_en   = accept;
        mem_rd_addr = item_idx;
      end
      ST_EXEC: begin
        mem_wr_en = out_free && exec_wr;
      end
      ST_WALK: begin
        mem_rd_en = !walk_cnt_r[PRECISION];
      end
      default: begin
        mem_wr_en = 1'b0;
      end
    endcase
  end

  // Estimate datapath helpers.
  assign term      = 32'h8000_0000 >> mem_rd_data;
  assign div_start = (state_r == ST_WALK) && walk_cnt_r[PRECISION] && !acc_vld_r;
  assign log_start = (state_r == ST_SEL) &&
                     (((e_r <= LIN_THR) && (zeros_r != '0)) ||
                      ((e_r > LARGE_THR) && (e_r < TOP_E)));
  assign log_in    = (e_r <= LIN_THR) ? hll_pkg::LOG_IN_W'(zeros_r)
                                      : (hll_pkg::LOG_IN_W'(0) - e_r[47:0]);
  assign diff      = (lin_r ? LIN_BASE : LARGE_BASE) - log_res;
  assign lin_card  = (64'(prod_r[59:30]) << PRECISION) >> 24;
  assign large_res = prod_r[59:22];

  // Main sequencer; holds the state and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      walk_cnt_r  <= '0;
      acc_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // The output register fills on a finished item and empties on a transfer.
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: begin
          walk_cnt_r <= walk_cnt_r + 1'b1;
          if (walk_cnt_r[PRECISION]) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            op_r       <= in_ch.data.opcode;
            idx_r      <= item_idx;
            val_r      <= item_val;
            s_r        <= '0;
            zeros_r    <= '0;
            walk_cnt_r <= '0;
            acc_vld_r  <= 1'b0;
            state_r    <= (in_ch.data.opcode == hll_pkg::OP_ESTIMATE) ? ST_WALK
                                                                       : ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (out_free) begin
            out_data_r  <= exec_out;
            state_r     <= ST_IDLE;
          end
        end
        ST_WALK: begin
          // Reads go out one a cycle; sums take each read's data in the cycle after it.
          acc_vld_r <= !walk_cnt_r[PRECISION];
          if (!walk_cnt_r[PRECISION]) begin
            walk_cnt_r <= walk_cnt_r + 1'b1;
          end
          if (acc_vld_r) begin
            s_r     <= s_r + S_W'(term);
            zeros_r <= zeros_r + {{PRECISION{1'b0}}, (mem_rd_data == '0)};
          end
          if (div_start) begin
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            e_r     <= div_q;
            state_r <= ST_SEL;
          end
        end
        ST_SEL: begin
          lin_r <= (e_r <= LIN_THR);
          if (log_start) begin
            card_r  <= e_r[47:16];
            sat_r   <= 1'b0;
            state_r <= ST_LOG;
          end else if ((e_r > LIN_THR) && (e_r >= TOP_E)) begin
            card_r  <= '1;
            sat_r   <= 1'b1;
            state_r <= ST_DONE;
          end else begin
            card_r  <= e_r[47:16];
            sat_r   <= 1'b0;
            state_r <= ST_DONE;
          end
        end
        ST_LOG: begin
          if (log_done) begin
            prod_r  <= diff[37:8] * hll_pkg::LN2_Q30;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          state_r <= ST_SCALE;
        end
        ST_SCALE: begin
          if (lin_r) begin
            card_r <= lin_card[31:0];
          end else if (large_res[37:32] != '0) begin
            card_r <= '1;
            sat_r  <= 1'b1;
          end else begin
            card_r <= large_res[31:0];
          end
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_data_r <= {{hll_pkg::RANK_W{1'b0}}, card_r, sat_r, 1'b0};
            state_r    <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  hll_ram #(
    .AW (PRECISION),
    .DW (hll_pkg::RANK_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  hll_div #(
    .N_W (DIVD_W),
    .D_W (S_W),
    .Q_W (hll_pkg::EST_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({NUM[NUM_W-1:0], {hll_pkg::DIV_EXTRA{1'b0}}}),
    .divisor  (s_r),
    .done     (div_done),
    .quotient (div_q)
  );

  hll_log2 u_log2 (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (log_start),
    .value  (log_in),
    .done   (log_done),
    .result (log_res)
  );

  // An accepted item always moves the sequencer out of the idle state in the next cycle.
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != ST_IDLE))
    else $error("item transfer did not start processing");

  // The store is written only by the clearing pass or a read-modify-write.
  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr_en |-> (state_r == ST_CLEAR || state_r == ST_EXEC))
    else $error("unexpected store write");

  // A saturated result always carries the clamped value.
  a_sat_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.saturated) |-> (out_data_r.cardinality == '1))
    else $error("saturated result without clamped cardinality");

  // A raised register never comes with read or estimate data.
  a_changed_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.changed) |->
      (out_data_r.read_value == '0 && out_data_r.cardinality == '0))
    else $error("changed flag mixed with other result data");

  // The divider finishes only while the sequencer waits for it.
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider finished outside the divide step");

endmodule

// ===== sim/tb_hyperloglog_sketch_core.sv =====
// ----------------------------------------------------------------------------
// tb_hyperloglog_sketch_core
// Self-checking bench: directed adds, merges, loads, reads, unknown opcodes and
// estimates, then random traffic; each result vs. a typed value or the sketch model.
// ----------------------------------------------------------------------------
module tb_hyperloglog_sketch_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PREC = 10;
  localparam int unsigned NREG = 1 << PREC;
  localparam int unsigned N_RANDOM = 860;

  logic clk;
  logic rst_n;
  hll_in_if  in_ch ();
  hll_out_if out_ch ();

  hyperloglog_sketch_core #(.PRECISION(PREC)) u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // Model state and the queue of results still owed by the block.
  logic [4:0]          sketch_ranks [NREG];
  hll_pkg::out_item_t  pending_results [$];
  int                  error_count;
  bit                  quiet_in;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("hyperloglog_sketch_core verification failed");
    $finish;
  end

  // Base-2 logarithm in Q32, fraction by repeated squaring of the mantissa.
  function automatic logic [63:0] log2_fixed(input logic [63:0] v);
    int unsigned n;
    logic [127:0] y;
    logic [63:0] frac;
    n = 0;
    frac = '0;
    while (n < 63 && (v >> (n + 1)) != 0) n++;
    if (n <= 31) y = 128'(v) << (31 - n);
    else y = 128'(v >> (n - 31));
    for (int i = 0; i < 32; i++) begin
      y = 128'(64'((y * y) >> 31));
      frac = frac << 1;
      if (y >= (128'd1 << 32)) begin
        frac[0] = 1'b1;
        y = y >> 1;
      end
    end
    return (64'(n) << 32) | frac;
  endfunction

  // Fixed-point estimate with linear-counting and large-range corrections.
  function automatic void predict_estimate(output logic [31:0] card, output logic sat);
    logic [63:0] s, zeros, num, q, r, e, alpha, diff, t, res;
    logic [63:0] m;
    m = NREG;
    s = 0;
    zeros = 0;
    sat = 1'b0;
    for (int i = 0; i < NREG; i++) begin
      s += 64'd1 << (31 - sketch_ranks[i]);
      if (sketch_ranks[i] == 0) zeros++;
    end
    alpha = ((64'd7213 * m) << 20) / (64'd10000 * m + 64'd10790);
    num = alpha * m * m;
    q = num / s;
    r = num % s;
    for (int k = 0; k < 27; k++) begin
      r = r << 1;
      q = q << 1;
      if (r >= s) begin
        r -= s;
        q[0] = 1'b1;
      end
    end
    e = q;
    if (e <= ((64'd5 * m) << 15)) begin
      if (zeros != 0) begin
        diff = (64'(PREC) << 32) - log2_fixed(zeros);
        t = ((diff >> 8) * 64'd744261118) >> 30;
        card = 32'((t * m) >> 24);
      end else begin
        card = 32'(e >> 16);
      end
    end else if (e > (64'd1 << 48) / 30) begin
      if (e >= (64'd1 << 48)) begin
        card = '1;
        sat = 1'b1;
      end else begin
        diff = (64'd48 << 32) - log2_fixed((64'd1 << 48) - e);
        res = ((diff >> 8) * 64'd744261118) >> 22;
        if (res > 64'hFFFF_FFFF) begin
          res = 64'hFFFF_FFFF;
          sat = 1'b1;
        end
        card = 32'(res);
      end
    end else begin
      card = 32'(e >> 16);
    end
  endfunction

  // Applies one operation to the model and returns the result it owes.
  function automatic hll_pkg::out_item_t apply_sketch_op(input hll_pkg::in_item_t it);
    hll_pkg::out_item_t o;
    logic [9:0] idx;
    logic [31:0] rest;
    logic [4:0] rank;
    o = '0;
    idx = it.reg_index;
    case (it.opcode)
      hll_pkg::OP_ADD: begin
        idx = it.hash_value[PREC-1:0];
        rest = it.hash_value << PREC;
        rank = 5'd1;
        if (rest == 0) begin
          rank = 5'(33 - PREC);
        end else begin
          while (!rest[31]) begin
            rest = rest << 1;
            rank++;
          end
        end
        if (rank > sketch_ranks[idx]) begin
          sketch_ranks[idx] = rank;
          o.changed = 1'b1;
        end
      end
      hll_pkg::OP_MERGE: begin
        if (it.reg_value > sketch_ranks[idx]) begin
          sketch_ranks[idx] = it.reg_value;
          o.changed = 1'b1;
        end
      end
      hll_pkg::OP_LOAD: sketch_ranks[idx] = it.reg_value;
      hll_pkg::OP_READ: o.read_value = sketch_ranks[idx];
      hll_pkg::OP_ESTIMATE: predict_estimate(o.cardinality, o.saturated);
      default: ;
    endcase
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    $display("MISMATCH %s: got 0x%08h, expected 0x%08h", what, got, want);
  endtask

  // Sends one item and queues the result that the model owes for it.
  task automatic send_item(input hll_pkg::in_item_t it);
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    forever begin
      @(posedge clk);
      if (in_ch.ready) break;
    end
    pending_results.push_back(apply_sketch_op(it));
    if (!quiet_in && $urandom_range(99) < 17) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  function automatic hll_pkg::in_item_t mk(input logic [2:0] op, input logic [31:0] h,
                                           input logic [9:0] i, input logic [4:0] v);
    hll_pkg::in_item_t it;
    it.opcode = op;
    it.hash_value = h;
    it.reg_index = i;
    it.reg_value = v;
    return it;
  endfunction

  // Directed table; typed-in results hold where they are evident.
  typedef struct {
    hll_pkg::in_item_t  item;
    bit                 typed;
    hll_pkg::out_item_t want;
  } dir_row_t;

  dir_row_t           dir_rows [$];
  hll_pkg::out_item_t typed_results [$];
  bit                 typed_flags [$];

  function automatic hll_pkg::out_item_t res(input logic [4:0] rd, input logic [31:0] c,
                                             input logic s, input logic ch);
    hll_pkg::out_item_t o;
    o.read_value = rd;
    o.cardinality = c;
    o.saturated = s;
    o.changed = ch;
    return o;
  endfunction

  function automatic hll_pkg::in_item_t random_item();
    int unsigned p;
    hll_pkg::in_item_t it;
    p = $urandom_range(99);
    it = mk(hll_pkg::OP_ADD, $urandom(), 10'($urandom()), 5'($urandom()));
    if (p < 45) it.opcode = hll_pkg::OP_ADD;
    else if (p < 60) it.opcode = hll_pkg::OP_MERGE;
    else if (p < 70) it.opcode = hll_pkg::OP_LOAD;
    else if (p < 90) it.opcode = hll_pkg::OP_READ;
    else if (p < 93) it.opcode = hll_pkg::OP_ESTIMATE;
    else it.opcode = 3'($urandom_range(7, 5));
    if (it.opcode != hll_pkg::OP_ADD || $urandom_range(3) == 0) return it;
    // Mostly sparse hashes so that high ranks appear often.
    it.hash_value = $urandom() >> $urandom_range(31);
    it.hash_value[PREC-1:0] = 10'($urandom());
    return it;
  endfunction

  // Stimulus.
  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    error_count = 0;
    quiet_in = 1'b0;
    foreach (sketch_ranks[i]) sketch_ranks[i] = '0;
    dir_rows = '{
      '{mk(hll_pkg::OP_ESTIMATE, 0, 0, 0), 1, res(0, 0, 0, 0)},
      '{mk(hll_pkg::OP_READ, 0, 10'd1023, 0), 1, res(0, 0, 0, 0)},
      '{mk(hll_pkg::OP_ADD, 32'h0000_0000, 0, 0), 1, res(0, 0, 0, 1)},
      '{mk(hll_pkg::OP_READ, 0, 10'd0, 0), 1, res(5'd23, 0, 0, 0)},
      '{mk(hll_pkg::OP_ADD, 32'hFFFF_FFFF, 0, 0), 1, res(0, 0, 0, 1)},
      '{mk(hll_pkg::OP_READ, 0, 10'd1023, 0), 1, res(5'd1, 0, 0, 0)},
      '{mk(hll_pkg::OP_ADD, 32'h0000_0400, 0, 0), 1, res(0, 0, 0, 0)},
      '{mk(hll_pkg::OP_ADD, 32'h0000_07FE, 0, 0), 0, '0},
      '{mk(hll_pkg::OP_MERGE, 0, 10'd5, 5'd31), 1, res(0, 0, 0, 1)},
      '{mk(hll_pkg::OP_MERGE, 0, 10'd5, 5'd0), 1, res(0, 0, 0, 0)},
      '{mk(hll_pkg::OP_READ, 0, 10'd5, 0), 1, res(5'd31, 0, 0, 0)},
      '{mk(hll_pkg::OP_LOAD, 32'hFFFF_FFFF, 10'd5, 5'd2), 1, res(0, 0, 0, 0)},
      '{mk(hll_pkg::OP_READ, 0, 10'd5, 0), 1, res(5'd2, 0, 0, 0)},
      '{mk(hll_pkg::OP_LOAD, 0, 10'd1023, 5'd0), 0, '0},
      '{mk(3'd5, 32'hFFFF_FFFF, 10'd1023, 5'd31), 1, res(0, 0, 0, 0)},
      '{mk(3'd6, 0, 0, 0), 1, res(0, 0, 0, 0)},
      '{mk(3'd7, 0, 10'd3, 5'd9), 1, res(0, 0, 0, 0)},
      '{mk(hll_pkg::OP_ESTIMATE, 0, 0, 0), 0, '0}
    };
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[r]) begin
      typed_flags.push_back(dir_rows[r].typed);
      typed_results.push_back(dir_rows[r].want);
      send_item(dir_rows[r].item);
    end
    // Random part; a quiet window and a full drain partway through.
    for (int n = 0; n < N_RANDOM; n++) begin
      quiet_in = (n >= 300 && n < 500);
      if (n == 600) begin
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      send_item(random_item());
    end
    // Every register at its largest rank drives the large-range clamp.
    for (int i = 0; i < NREG; i++) send_item(mk(hll_pkg::OP_LOAD, 0, 10'(i), 5'd31));
    send_item(mk(hll_pkg::OP_ESTIMATE, 0, 0, 0));
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("hyperloglog_sketch_core verification clean");
    end else begin
      $display("hyperloglog_sketch_core verification failed");
    end
    $finish;
  end

  // Receiver: random stalls, checks each transfer against the oldest owed result.
  always @(posedge clk) begin
    hll_pkg::out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result transfer", 32'(out_ch.data.cardinality), 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (typed_flags.size() != 0) begin
          if (typed_flags[0]) want = typed_results[0];
          void'(typed_flags.pop_front());
          void'(typed_results.pop_front());
        end
        if (out_ch.data.read_value != want.read_value)
          report_mismatch("read_value", 32'(out_ch.data.read_value), 32'(want.read_value));
        if (out_ch.data.cardinality != want.cardinality)
          report_mismatch("cardinality", out_ch.data.cardinality, want.cardinality);
        if (out_ch.data.saturated != want.saturated)
          report_mismatch("saturated", 32'(out_ch.data.saturated), 32'(want.saturated));
        if (out_ch.data.changed != want.changed)
          report_mismatch("changed", 32'(out_ch.data.changed), 32'(want.changed));
      end
    end
    out_ch.ready <= quiet_in || ($urandom_range(99) >= 17);
  end

endmodule

// ===== hyperloglog_sketch_core.f =====
src/hll_pkg.sv
src/hll_if.sv
src/hll_ram.sv
src/hll_div.sv
src/hll_log2.sv
src/hyperloglog_sketch_core.sv
sim/tb_hyperloglog_sketch_core.sv
